// File: hw/rtl/stca_pkg.sv
package stca_pkg;

    localparam int ROW_W       = 64;
    localparam int DRAW_W      = 7;
    localparam int POS_W       = 6;
    localparam int PROB_W      = 7;
    localparam int RADIUS_W    = 2;
    localparam int TABLE_W     = 56;
    localparam int SUM_W       = 3;
    localparam int MAX_RADIUS  = 3;
    localparam int WIN_W       = 2 * MAX_RADIUS + 1;
    localparam int CFG_DATA_W  = 56;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_EVOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_TABLE    = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;

    typedef struct packed {
        logic              evolve;
        logic [ROW_W-1:0]  row;
        logic [DRAW_W-1:0] draw;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [TABLE_W-1:0]  prob_table;
    } t_cfg;

endpackage

// File: hw/rtl/stca_in_if.sv
interface stca_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [stca_pkg::ROW_W-1:0]   row_bits;
    logic [stca_pkg::DRAW_W-1:0]  random_draw;

    modport source (output valid, command, row_bits, random_draw, input ready);
    modport sink   (input valid, command, row_bits, random_draw, output ready);
endinterface

// File: hw/rtl/stca_out_if.sv
interface stca_out_if;
    logic                        valid;
    logic                        ready;
    logic                        cell_value;
    logic [stca_pkg::POS_W-1:0]  cell_position;
    logic                        generation_end;

    modport source (output valid, cell_value, cell_position, generation_end, input ready);
    modport sink   (input valid, cell_value, cell_position, generation_end, output ready);
endinterface

// File: hw/rtl/stca_front.sv
module stca_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stca_in_if.sink           i_in,
    input  logic              i_pop,
    output stca_pkg::t_qhead  o_head
);
    import stca_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push;
    logic               pop;
    t_item              w_item;

    assign i_in.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != '0);

    always_comb begin
        w_item.evolve = (i_in.command == CMD_EVOLVE);
        w_item.row    = i_in.row_bits;
        w_item.draw   = i_in.random_draw;
    end

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

endmodule

// File: hw/rtl/stca_back.sv
module stca_back #(
    parameter int CELLS      = 64,
    parameter int RULE_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stca_pkg::t_cfg    i_cfg,
    input  stca_pkg::t_qhead  i_head,
    output logic              o_pop,
    stca_out_if.source        o_res
);
    import stca_pkg::*;

    localparam int               IDX_W    = $clog2(CELLS);
    localparam logic [SUM_W-1:0] MAX_SLOT = SUM_W'(RULE_SLOTS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

    logic [CELLS-1:0]              r_cur, r_next, n_next;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_out_valid;
    logic                          r_val;
    logic [IDX_W-1:0]              r_pos;
    logic                          r_end;

    logic [CELLS+2*MAX_RADIUS-1:0] ext;
    logic [WIN_W-1:0]              win;
    logic [SUM_W-1:0]              lo, hi;
    logic [SUM_W-1:0]              sum;
    logic [SUM_W-1:0]              slot;
    logic [PROB_W-1:0]             prob;
    logic                          bit_new;
    logic                          last;
    logic                          do_evolve;

    assign o_pop     = i_head.valid && (!i_head.item.evolve || !r_out_valid || o_res.ready);
    assign do_evolve = o_pop && i_head.item.evolve;

    always_comb begin
        ext = {{MAX_RADIUS{1'b0}}, r_cur, {MAX_RADIUS{1'b0}}};
        win = ext[r_idx +: WIN_W];
        lo  = SUM_W'(MAX_RADIUS) - {1'b0, i_cfg.radius};
        hi  = SUM_W'(MAX_RADIUS) + {1'b0, i_cfg.radius};
        sum = '0;
        for (int j = 0; j < WIN_W; j++) begin
            if (win[j] && (SUM_W'(j) >= lo) && (SUM_W'(j) <= hi)) begin
                sum = sum + SUM_W'(1);
            end
        end
        slot    = (sum > MAX_SLOT) ? MAX_SLOT : sum;
        prob    = i_cfg.prob_table[PROB_W*slot +: PROB_W];
        bit_new = (i_head.item.draw < prob);
        last    = (r_idx == LAST_IDX);
        n_next        = r_next;
        n_next[r_idx] = bit_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_next      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && !i_head.item.evolve) begin
                r_cur  <= i_head.item.row[CELLS-1:0];
                r_next <= '0;
                r_idx  <= '0;
            end else if (do_evolve) begin
                r_next <= n_next;
                if (last) begin
                    r_cur <= n_next;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (do_evolve) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_evolve) begin
            r_val <= bit_new;
            r_pos <= r_idx;
            r_end <= last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.cell_value     = r_val;
    assign o_res.cell_position  = POS_W'(r_pos);
    assign o_res.generation_end = r_end;

endmodule

// File: hw/rtl/stochastic_totalistic_ca_step_unit.sv
// Stochastic totalistic cellular automaton, one cell per transfer. A load
// transfer replaces the row and restarts at cell 0; it gives no result. An
// evolve transfer updates the next cell from the ones in its clipped window and
// the draw, and gives one result. Items pass through a two-entry queue into the
// cell unit, which retires one item per cycle: sustained rate is one item per
// clock while the result side takes each result. A result is held in an output
// register once its item leaves the queue; while it waits, loads keep retiring
// and the queue takes up to two more items before the input stalls.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module stochastic_totalistic_ca_step_unit #(
    parameter int CELLS      = 64,
    parameter int RULE_SLOTS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    stca_in_if.sink                             i_in,
    stca_out_if.source                          o_res
);
    import stca_pkg::*;

    t_cfg   r_cfg;
    t_qhead head;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius     <= RADIUS_RESET;
            r_cfg.prob_table <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_RADIUS: r_cfg.radius     <= i_cfg_data[RADIUS_W-1:0];
                CFG_PROB_TABLE:    r_cfg.prob_table <= i_cfg_data[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    stca_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    stca_back #(
        .CELLS      (CELLS),
        .RULE_SLOTS (RULE_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    a_end_at_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.generation_end |-> o_res.cell_position == POS_W'(CELLS - 1))
        else $error("generation end away from last cell");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("queue pop while empty");

    a_load_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head.valid && !head.item.evolve |-> pop)
        else $error("load held in queue");

endmodule
